/* rtl/ste_pkg.sv */
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants for the sprite tile expander.
// ----------------------------------------------------------------------------
package ste_pkg;

	// Descriptor and result field widths
	localparam int ATTR_W   = 16;
	localparam int TILE_W   = 14;
	localparam int COLOR_W  = 4;
	localparam int SCR_W    = 10;
	localparam int POS_W    = 12;
	localparam int CNT_W    = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int HSCR_W     = 10;
	localparam int VSCR_W     = 9;
	localparam int CLIP_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_H_SCROLL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_V_SCROLL    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

	localparam logic [CLIP_W-1:0] CLIP_BOTTOM_RST = 9'd383;

	// Screen size defaults
	localparam int SCREEN_WIDTH_DEF  = 512;
	localparam int SCREEN_HEIGHT_DEF = 384;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic col_adv;
		logic row_adv;
		logic skip;
		logic capture;
		logic push;
		logic push_last;
	} ste_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic col_last;
		logic row_last;
		logic col_skip;
		logic col_stop;
		logic row_vis;
		logic pend_valid;
		logic out_free;
	} ste_status_t;

endpackage

/* rtl/ste_in_if.sv */
// ----------------------------------------------------------------------------
// ste_in_if
// Descriptor channel: three attribute words with valid/ready.
// ----------------------------------------------------------------------------
interface ste_in_if;
	logic                        valid;
	logic                        ready;
	logic [ste_pkg::ATTR_W-1:0]  attr_size_y;
	logic [ste_pkg::ATTR_W-1:0]  attr_tile;
	logic [ste_pkg::ATTR_W-1:0]  attr_x_color;

	modport source (output valid, output attr_size_y, output attr_tile,
		output attr_x_color, input ready);
	modport sink (input valid, input attr_size_y, input attr_tile,
		input attr_x_color, output ready);
endinterface

/* rtl/ste_out_if.sv */
// ----------------------------------------------------------------------------
// ste_out_if
// Tile draw command channel with valid/ready.
// ----------------------------------------------------------------------------
interface ste_out_if;
	logic                              valid;
	logic                              ready;
	logic [ste_pkg::TILE_W-1:0]        tile_index;
	logic [ste_pkg::COLOR_W-1:0]       palette_color;
	logic                              flip_h;
	logic                              flip_v;
	logic signed [ste_pkg::SCR_W-1:0]  screen_x;
	logic signed [ste_pkg::SCR_W-1:0]  screen_y;
	logic                              last_tile;

	modport source (output valid, output tile_index, output palette_color,
		output flip_h, output flip_v, output screen_x, output screen_y,
		output last_tile, input ready);
	modport sink (input valid, input tile_index, input palette_color,
		input flip_h, input flip_v, input screen_x, input screen_y,
		input last_tile, output ready);
endinterface

/* rtl/ste_ctrl.sv */
// ----------------------------------------------------------------------------
// ste_ctrl
// Walk sequencer: accepts a descriptor, steps one tile per cycle unless held
// by a stalled output, flushes the held command marked last at walk end.
// ----------------------------------------------------------------------------
module ste_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 desc_valid,
	output logic                 desc_ready,
	input  ste_pkg::ste_status_t st,
	output ste_pkg::ste_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Decide the action for this cycle
	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		desc_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (desc_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				priority if (st.col_stop) begin
					state_nxt = ST_FLUSH;
				end else if (st.col_skip) begin
					cmd.skip    = 1'b1;
					cmd.col_adv = 1'b1;
					if (st.col_last) state_nxt = ST_FLUSH;
				end else if (st.row_vis && st.pend_valid && !st.out_free) begin
					// hold: held command cannot move to the output yet
					cmd = '0;
				end else begin
					cmd.row_adv = 1'b1;
					if (st.row_vis) begin
						cmd.capture = 1'b1;
						cmd.push    = st.pend_valid;
					end
					if (st.row_last) begin
						cmd.col_adv = 1'b1;
						if (st.col_last) state_nxt = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!st.pend_valid) begin
					state_nxt = ST_IDLE;
				end else if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A new descriptor is only taken with nothing held from the previous one
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !st.pend_valid)
		else $error("descriptor loaded while a command is still held");

	// Leaving the walk always passes through the flush step
	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |=> (state_q == ST_WALK) || (state_q == ST_FLUSH))
		else $error("walk left without flush");

endmodule

/* rtl/ste_datapath.sv */
// ----------------------------------------------------------------------------
// ste_datapath
// Configuration registers, descriptor decode, walk counters and positions,
// the held command and the output register.
// ----------------------------------------------------------------------------
module ste_datapath #(
	parameter int SCREEN_WIDTH  = ste_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = ste_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ste_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ste_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [ste_pkg::ATTR_W-1:0]      attr_size_y,
	input  logic [ste_pkg::ATTR_W-1:0]      attr_tile,
	input  logic [ste_pkg::ATTR_W-1:0]      attr_x_color,
	input  ste_pkg::ste_cmd_t               cmd,
	output ste_pkg::ste_status_t            st,
	ste_out_if.source                       out
);

	localparam int PW = ste_pkg::POS_W;
	localparam int TW = ste_pkg::TILE_W;
	localparam int CW = ste_pkg::CNT_W;
	localparam int SW = ste_pkg::SCR_W;

	localparam logic [PW-1:0]        SW_U   = PW'(SCREEN_WIDTH);
	localparam logic [PW-1:0]        SH_U   = PW'(SCREEN_HEIGHT);
	localparam logic signed [PW-1:0] SW_S   = PW'(SCREEN_WIDTH);
	localparam logic signed [PW-1:0] STEP_P = PW'(16);
	localparam logic signed [PW-1:0] STEP_N = -PW'(16);
	localparam logic signed [PW-1:0] EDGE_L = -PW'(16);
	localparam logic [PW-1:0]        XWRAP  = PW'(1024);
	localparam logic [PW-1:0]        YWRAP  = PW'(512);

	// Configuration registers
	logic [ste_pkg::HSCR_W-1:0] h_scroll_q;
	logic [ste_pkg::VSCR_W-1:0] v_scroll_q;
	logic [ste_pkg::CLIP_W-1:0] clip_top_q;
	logic [ste_pkg::CLIP_W-1:0] clip_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_scroll_q    <= '0;
			v_scroll_q    <= '0;
			clip_top_q    <= '0;
			clip_bottom_q <= ste_pkg::CLIP_BOTTOM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ste_pkg::REG_H_SCROLL:    h_scroll_q    <= cfg_data[ste_pkg::HSCR_W-1:0];
				ste_pkg::REG_V_SCROLL:    v_scroll_q    <= cfg_data[ste_pkg::VSCR_W-1:0];
				ste_pkg::REG_CLIP_TOP:    clip_top_q    <= cfg_data[ste_pkg::CLIP_W-1:0];
				ste_pkg::REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[ste_pkg::CLIP_W-1:0];
			endcase
		end
	end

	// Decode the descriptor and compute the start corner
	logic [CW-1:0]  d_cols_m1;
	logic [CW-1:0]  d_rows_m1;
	logic [CW:0]    d_rows;
	logic           d_abs;
	logic [9:0]     d_ux;
	logic [8:0]     d_uy;
	logic [PW-1:0]  d_ux_w;
	logic [PW-1:0]  d_uy_w;
	logic [PW-1:0]  d_x0;
	logic [PW-1:0]  d_y0;

	always_comb begin
		d_cols_m1 = attr_size_y[2:0];
		d_rows_m1 = attr_size_y[5:3];
		d_rows    = {1'b0, d_rows_m1} + 4'd1;
		d_abs     = attr_size_y[15];
		d_ux = attr_x_color[15:6]
			- (d_abs ? 10'd0 : h_scroll_q)
			+ (attr_tile[14] ? {3'b0, d_cols_m1, 4'b0} : 10'd0);
		d_uy = 9'd0 - attr_size_y[14:6]
			- (d_abs ? 9'd0 : v_scroll_q)
			- (attr_tile[15] ? 9'd16 : {1'b0, d_rows, 4'b0});
		d_ux_w = {2'b0, d_ux};
		d_uy_w = {3'b0, d_uy};
		d_x0 = (d_ux_w >= SW_U) ? d_ux_w - XWRAP : d_ux_w;
		d_y0 = (d_uy_w >= SH_U) ? d_uy_w - YWRAP : d_uy_w;
	end

	// Walk state
	logic [CW-1:0]        cols_m1_q;
	logic [CW-1:0]        rows_m1_q;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        row_q;
	logic                 hf_q;
	logic                 vf_q;
	logic [3:0]           color_q;
	logic [TW-1:0]        tile_q;
	logic signed [PW-1:0] sx_q;
	logic signed [PW-1:0] sy_q;
	logic signed [PW-1:0] y0_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cols_m1_q <= d_cols_m1;
			rows_m1_q <= d_rows_m1;
			hf_q      <= attr_tile[14];
			vf_q      <= attr_tile[15];
			color_q   <= attr_x_color[3:0];
			tile_q    <= attr_tile[TW-1:0];
			sx_q      <= d_x0;
			sy_q      <= d_y0;
			y0_q      <= d_y0;
			col_q     <= '0;
			row_q     <= '0;
		end else begin
			// advance the tile number
			if (cmd.skip) begin
				tile_q <= tile_q + TW'({1'b0, rows_m1_q} + 4'd1);
			end else if (cmd.row_adv) begin
				tile_q <= tile_q + TW'(1);
			end
			// advance column or row
			if (cmd.col_adv) begin
				col_q <= col_q + CW'(1);
				sx_q  <= sx_q + (hf_q ? STEP_N : STEP_P);
				row_q <= '0;
				sy_q  <= y0_q;
			end else if (cmd.row_adv) begin
				row_q <= row_q + CW'(1);
				sy_q  <= sy_q + (vf_q ? STEP_N : STEP_P);
			end
		end
	end

	// Held command
	logic          pend_valid_q;
	logic [TW-1:0] pend_tile_q;
	logic [SW-1:0] pend_x_q;
	logic [SW-1:0] pend_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pend_tile_q <= tile_q;
			pend_x_q    <= sx_q[SW-1:0];
			pend_y_q    <= sy_q[SW-1:0];
		end
	end

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out.tile_index    <= pend_tile_q;
			out.palette_color <= color_q;
			out.flip_h        <= hf_q;
			out.flip_v        <= vf_q;
			out.screen_x      <= pend_x_q;
			out.screen_y      <= pend_y_q;
			out.last_tile     <= cmd.push_last;
		end
	end

	assign out.valid = out_valid_q;

	// Status to the controller
	logic signed [PW-1:0] top_m16;
	logic signed [PW-1:0] bot_s;

	always_comb begin
		top_m16       = $signed({3'b0, clip_top_q}) - STEP_P;
		bot_s         = $signed({3'b0, clip_bottom_q});
		st.col_last   = (col_q == cols_m1_q);
		st.row_last   = (row_q == rows_m1_q);
		st.col_skip   = (sx_q <= EDGE_L);
		st.col_stop   = (sx_q >= SW_S);
		st.row_vis    = (sy_q > top_m16) && (sy_q <= bot_s);
		st.pend_valid = pend_valid_q;
		st.out_free   = !out_valid_q || out.ready;
	end

	// A push never overwrites a command still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out.ready))
		else $error("output command overwritten");

	// Capturing over a held command must move that command out
	a_capture_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && pend_valid_q) |-> cmd.push)
		else $error("held command lost on capture");

	// The last-tile mark goes out only with nothing new captured
	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_last |=> !pend_valid_q && out_valid_q && out.last_tile)
		else $error("last tile push left a command behind");

endmodule

/* rtl/sprite_tile_expander_top.sv */
// ----------------------------------------------------------------------------
// sprite_tile_expander_top
// Expands one motion-object descriptor into one draw command per visible tile.
// ----------------------------------------------------------------------------
// Flow: a visible tile is held until the next visible tile is captured or
// the flush step, then moves to the output register. The walk visits one
// tile (or one skipped column) per cycle unless the held command cannot move
// to a stalled output. The walk is stepped by the single walk counter pair.
// Reset: clears the sequencer, held and output valid flags, and loads the
// configuration registers with 0, 0, 0 and 383.
// ----------------------------------------------------------------------------
module sprite_tile_expander_top #(
	parameter int SCREEN_WIDTH  = ste_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = ste_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ste_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ste_pkg::CFG_DATA_W-1:0]  cfg_data,
	ste_in_if.sink                          desc,
	ste_out_if.source                       cmd
);

	ste_pkg::ste_cmd_t    ctl_cmd;
	ste_pkg::ste_status_t dp_status;
	logic                 desc_ready;

	assign desc.ready = desc_ready;

	// Sequencer
	ste_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc.valid),
		.desc_ready (desc_ready),
		.st         (dp_status),
		.cmd        (ctl_cmd)
	);

	// Datapath
	ste_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.attr_size_y  (desc.attr_size_y),
		.attr_tile    (desc.attr_tile),
		.attr_x_color (desc.attr_x_color),
		.cmd          (ctl_cmd),
		.st           (dp_status),
		.out          (cmd)
	);

endmodule
